>>> hdl/lfuc_pkg.sv
// Shared constants and codes for the LFU cache table.
package lfuc_pkg;
  localparam int CAP_W             = 5;
  localparam int DATA_W            = 32;
  localparam int MAX_ENTRIES_DEF   = 16;
  localparam int COUNT_WIDTH_DEF   = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;
endpackage

>>> hdl/lfu_cache_table_core.sv
// LFU cache table top level: tag lanes, victim scan and control.
//
//   channel   direction  handshake             payload
//   request   in         start / busy          action, lookup_key, store_value
//   result    out        result_valid strobe   hit, read_value
//   config    in         cfg_we                cfg_wdata (capacity_in_use)
//
// A get does a key compare over all lanes, then the value memory read.
// A put that hits or finds a free slot is written in the match state after acceptance.
// A put of a new key into a full table scans MAX_ENTRIES lanes, one per cycle,
// for the victim, then inserts.
// Reset clears valid bits, occupancy and control; capacity resets to 16.
// The receiver cannot stall; result_valid is high for one cycle per get.
module lfu_cache_table_core #(
  parameter int MAX_ENTRIES = lfuc_pkg::MAX_ENTRIES_DEF,
  parameter int COUNT_WIDTH = lfuc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              action,
  input  logic signed [lfuc_pkg::DATA_W-1:0] lookup_key,
  input  logic signed [lfuc_pkg::DATA_W-1:0] store_value,
  output logic                              result_valid,
  output logic                              hit,
  output logic signed [lfuc_pkg::DATA_W-1:0] read_value,
  input  logic                              cfg_we,
  input  logic [lfuc_pkg::CAP_W-1:0]        cfg_wdata
);
  import lfuc_pkg::*;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);
  localparam logic [CMP_W-1:0] MAX_CMP  = CMP_W'(MAX_ENTRIES);

  typedef enum logic [2:0] {S_IDLE, S_MATCH, S_OUT, S_SCAN, S_EVICT} state_t;

  state_t                    state;
  logic [CAP_W-1:0]          capacity;
  logic                      act_q;
  logic [DATA_W-1:0]         key_q;
  logic [DATA_W-1:0]         val_q;
  logic                      hit_q;
  logic [MAX_ENTRIES-1:0]    valid;
  logic [DATA_W-1:0]         keys  [MAX_ENTRIES];
  logic [COUNT_WIDTH-1:0]    cnt   [MAX_ENTRIES];
  logic [IDX_W-1:0]          rank  [MAX_ENTRIES];
  logic [OCC_W-1:0]          occupancy;
  logic [IDX_W-1:0]          scan_idx;
  logic                      best_found;
  logic [IDX_W-1:0]          best_idx;
  logic [COUNT_WIDTH-1:0]    best_cnt;
  logic [IDX_W-1:0]          best_rank;

  logic                      match;
  logic [IDX_W-1:0]          match_idx;
  logic [IDX_W-1:0]          match_rank;
  logic [IDX_W-1:0]          free_idx;
  logic [CMP_W-1:0]          cap_eff;
  logic                      full;
  logic                      ram_we;
  logic [IDX_W-1:0]          ram_waddr;
  logic [DATA_W-1:0]         ram_rdata;
  logic                      accept;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE) && (state != S_OUT);

  always_comb begin
    match      = 1'b0;
    match_idx  = '0;
    match_rank = '0;
    for (int j = 0; j < MAX_ENTRIES; j++) begin
      if (valid[j] && keys[j] == key_q) begin
        match      = 1'b1;
        match_idx  = IDX_W'(j);
        match_rank = rank[j];
      end
    end
    free_idx = '0;
    for (int j = MAX_ENTRIES - 1; j >= 0; j--) begin
      if (!valid[j]) begin
        free_idx = IDX_W'(j);
      end
    end
    cap_eff = (CMP_W'(capacity) > MAX_CMP) ? MAX_CMP : CMP_W'(capacity);
    full    = CMP_W'(occupancy) >= cap_eff;
  end

  assign ram_we    = (state == S_MATCH && act_q == ACT_PUT && capacity != '0 &&
                      (match || !full)) || (state == S_EVICT);
  assign ram_waddr = (state == S_EVICT) ? best_idx : (match ? match_idx : free_idx);

  lfuc_value_ram #(.DEPTH(MAX_ENTRIES), .AW(IDX_W)) u_value_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (val_q),
    .raddr (match_idx),
    .rdata (ram_rdata)
  );

  assign result_valid = (state == S_OUT);
  assign hit          = hit_q;
  assign read_value   = hit_q ? ram_rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      capacity  <= CAP_RESET;
      valid     <= '0;
      occupancy <= '0;
      hit_q     <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      unique case (state)
        S_IDLE, S_OUT: begin
          if (accept) begin
            act_q <= action;
            key_q <= lookup_key;
            val_q <= store_value;
            state <= S_MATCH;
          end else begin
            state <= S_IDLE;
          end
        end
        S_MATCH: begin
          if (act_q == ACT_GET) begin
            hit_q <= match;
            state <= S_OUT;
          end else if (!match && capacity != '0 && full) begin
            state <= S_SCAN;
          end else begin
            state <= S_IDLE;
          end
          if (match && (act_q == ACT_GET || capacity != '0)) begin
            for (int j = 0; j < MAX_ENTRIES; j++) begin
              if (valid[j] && rank[j] < match_rank) begin
                rank[j] <= rank[j] + 1'b1;
              end
            end
            rank[match_idx] <= '0;
            if (cnt[match_idx] != '1) begin
              cnt[match_idx] <= cnt[match_idx] + 1'b1;
            end
          end else if (!match && act_q == ACT_PUT && capacity != '0) begin
            if (!full) begin
              for (int j = 0; j < MAX_ENTRIES; j++) begin
                if (valid[j]) begin
                  rank[j] <= rank[j] + 1'b1;
                end
              end
              valid[free_idx] <= 1'b1;
              keys[free_idx]  <= key_q;
              cnt[free_idx]   <= COUNT_WIDTH'(1);
              rank[free_idx]  <= '0;
              occupancy       <= occupancy + 1'b1;
            end else begin
              scan_idx   <= '0;
              best_found <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          if (valid[scan_idx] && (!best_found || cnt[scan_idx] < best_cnt ||
              (cnt[scan_idx] == best_cnt && rank[scan_idx] > best_rank))) begin
            best_found <= 1'b1;
            best_idx   <= scan_idx;
            best_cnt   <= cnt[scan_idx];
            best_rank  <= rank[scan_idx];
          end
          if (scan_idx == LAST_IDX) begin
            state <= S_EVICT;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        S_EVICT: begin
          for (int j = 0; j < MAX_ENTRIES; j++) begin
            if (valid[j] && rank[j] < best_rank) begin
              rank[j] <= rank[j] + 1'b1;
            end
          end
          keys[best_idx] <= key_q;
          cnt[best_idx]  <= COUNT_WIDTH'(1);
          rank[best_idx] <= '0;
          state          <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy) else $error("accepted word did not raise busy");
  a_result_get: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == S_MATCH && act_q == ACT_GET))
    else $error("result strobe without a get");
  a_occ_count: assert property (@(posedge clk) disable iff (rst)
    OCC_W'($countones(valid)) == occupancy) else $error("occupancy mismatch");
  a_occ_max: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(occupancy) <= MAX_CMP) else $error("occupancy above table size");
endmodule

>>> hdl/lfuc_value_ram.sv
// Value store: one write port, one read port with registered read data.
module lfuc_value_ram #(
  parameter int DEPTH = lfuc_pkg::MAX_ENTRIES_DEF,
  parameter int AW    = 4
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [lfuc_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]               raddr,
  output logic [lfuc_pkg::DATA_W-1:0] rdata
);
  import lfuc_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> tb/testbench.sv
// Testbench for the LFU cache table: random get/put words checked against a model.
class lfu_scoreboard;
  localparam int N = lfuc_pkg::MAX_ENTRIES_DEF;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  logic [4:0] capacity;
  bit         valid [N];
  logic [31:0] key [N];
  logic [31:0] value [N];
  logic [15:0] uses [N];
  int unsigned rank [N];
  int unsigned occupancy;
  logic        hit_q [$];
  logic [31:0] value_q [$];
  int errors;
  int gets;
  int hits;
  int evictions;

  function new();
    capacity = lfuc_pkg::CAP_RESET;
    occupancy = 0;
    errors = 0;
    gets = 0;
    hits = 0;
    evictions = 0;
    foreach (valid[i]) begin
      valid[i] = 0;
      key[i] = '0;
      value[i] = '0;
      uses[i] = '0;
      rank[i] = 0;
    end
  endfunction

  function int find_slot(logic [31:0] k);
    for (int i = 0; i < N; i++)
      if (valid[i] && key[i] == k) return i;
    return -1;
  endfunction

  function void touch(int s);
    int unsigned old;
    old = rank[s];
    for (int i = 0; i < N; i++)
      if (valid[i] && rank[i] < old) rank[i]++;
    rank[s] = 0;
    if (uses[s] < COUNT_MAX) uses[s]++;
  endfunction

  function void insert(logic [31:0] k, logic [31:0] v);
    int s;
    int unsigned cap;
    int unsigned old;
    s = -1;
    cap = (capacity > N) ? N : capacity;
    if (occupancy >= cap) begin
      for (int i = 0; i < N; i++)
        if (valid[i] && (s < 0 || uses[i] < uses[s] ||
                         (uses[i] == uses[s] && rank[i] > rank[s])))
          s = i;
      if (s >= 0) begin
        old = rank[s];
        valid[s] = 0;
        for (int i = 0; i < N; i++)
          if (valid[i] && rank[i] > old) rank[i]--;
        if (occupancy > 0) occupancy--;
        evictions++;
      end
    end
    if (s < 0)
      for (int i = 0; i < N; i++)
        if (!valid[i]) begin
          s = i;
          break;
        end
    if (s < 0) return;
    for (int i = 0; i < N; i++)
      if (valid[i]) rank[i]++;
    valid[s] = 1;
    key[s] = k;
    value[s] = v;
    uses[s] = 1;
    rank[s] = 0;
    occupancy++;
  endfunction

  function void note_word(logic act, logic [31:0] k, logic [31:0] v);
    int s;
    s = find_slot(k);
    if (act == lfuc_pkg::ACT_GET) begin
      gets++;
      if (s >= 0) begin
        hits++;
        touch(s);
        hit_q.push_back(1'b1);
        value_q.push_back(value[s]);
      end else begin
        hit_q.push_back(1'b0);
        value_q.push_back('0);
      end
    end else if (capacity != 0) begin
      if (s >= 0) begin
        value[s] = v;
        touch(s);
      end else begin
        insert(k, v);
      end
    end
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task check_result(logic h, logic [31:0] v);
    logic eh;
    logic [31:0] ev;
    if (hit_q.size() == 0) begin
      report($sformatf("unexpected result hit=%0b value=%h", h, v));
      return;
    end
    eh = hit_q.pop_front();
    ev = value_q.pop_front();
    if (h !== eh) report($sformatf("hit got %b expected %b", h, eh));
    if (v !== ev) report($sformatf("read_value got %h expected %h", v, ev));
  endtask
endclass

module testbench;
  import lfuc_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic action = ACT_GET;
  logic signed [DATA_W-1:0] lookup_key = '0;
  logic signed [DATA_W-1:0] store_value = '0;
  logic cfg_we = 0;
  logic [CAP_W-1:0] cfg_wdata = '0;
  wire busy, result_valid, hit;
  wire signed [DATA_W-1:0] read_value;

  lfu_cache_table_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .lookup_key(lookup_key), .store_value(store_value),
    .result_valid(result_valid), .hit(hit), .read_value(read_value),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  lfu_scoreboard board = new();
  int cycles = 0;
  int words = 0;
  bit calm = 0;
  int gap_left = 0;
  logic [31:0] key_pool [8];

  localparam int LIMIT = 400000;
  localparam int SETTLE = MAX_ENTRIES_DEF + 8;

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (result_valid) board.check_result(hit, read_value);
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send(logic act, logic [31:0] k, logic [31:0] v);
    if (!calm && gap_left == 0 && $urandom_range(0, 5) == 0)
      gap_left = $urandom_range(1, 19);
    if (gap_left > 0) start <= 0;
    while (gap_left > 0) begin
      @(posedge clk);
      gap_left--;
    end
    start <= 1;
    action <= act;
    lookup_key <= k;
    store_value <= v;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    board.note_word(act, k, v);
    words++;
  endtask

  task automatic drain();
    start <= 0;
    while (board.hit_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_capacity(logic [4:0] c);
    drain();
    cfg_we <= 1;
    cfg_wdata <= c;
    @(posedge clk);
    board.capacity = c;
    cfg_we <= 0;
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  task automatic random_phase(int n, int gets_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < gets_pct)
        send(ACT_GET, pick_key(), $urandom);
      else
        send(ACT_PUT, pick_key(), $urandom);
    end
  endtask

  initial begin
    logic [4:0] caps [6];
    caps = '{5'd16, 5'd0, 5'd1, 5'd31, 5'd3, 5'd8};
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, update, eviction, miss
    send(ACT_GET, 32'h8000_0000, 32'h0);
    send(ACT_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send(ACT_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send(ACT_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(ACT_PUT, 32'h0, 32'h0);
    send(ACT_GET, 32'h8000_0000, 32'h0);
    send(ACT_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send(ACT_PUT, 32'h0, 32'h1234_5678);
    send(ACT_GET, 32'h0, 32'h0);
    for (int i = 0; i < 14; i++) send(ACT_PUT, 32'h100 + i, i);
    send(ACT_GET, 32'hFFFF_FFFF, 32'h0);
    send(ACT_GET, 32'h101, 32'h0);

    for (int p = 0; p < 6; p++) begin
      set_capacity(caps[p]);
      foreach (key_pool[i])
        key_pool[i] = (p % 2) ? $urandom : $urandom_range(0, 24) - 12;
      random_phase(230, 50);
    end

    // repeat hits on one entry, then evict around it
    set_capacity(5'd2);
    send(ACT_PUT, 32'h55, 32'hA5A5_A5A5);
    calm = 1;
    for (int i = 0; i < 40; i++) send(ACT_GET, 32'h55, 32'h0);
    send(ACT_PUT, 32'h66, 32'h1);
    send(ACT_PUT, 32'h77, 32'h2);
    send(ACT_GET, 32'h55, 32'h0);
    send(ACT_GET, 32'h66, 32'h0);

    set_capacity(5'd16);
    calm = 0;
    random_phase(150, 50);
    calm = 1;
    random_phase(150, 50);

    drain();
    $display("ran %0d words, %0d gets (%0d hits), %0d evictions, 7 capacity settings",
             words, board.gets, board.hits, board.evictions);
    if (board.errors == 0 && board.hit_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
